// ----- rtl/core/sha256_pkg.sv -----
// Package for the SHA-256 byte-stream hasher: beat types, controller types,
// round constants, initial hash values and the sigma functions.
// No dependencies.
`timescale 1ns / 1ps

package sha256_pkg;

  // Item kinds on the message channel
  localparam logic KIND_ABSORB = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Padding constants
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_FILL = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_INDEX = 3'd7;

  // One message beat
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } msg_beat_t;

  // One digest beat
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD2,
    ST_DONE
  } sha256_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic absorb;     // write byte into block buffer
    logic finish;     // load first padded block
    logic len_block;  // load zero block carrying the length
    logic start;      // copy chain into working vars, clear round count
    logic round;      // run one compression round
    logic fold;       // add working vars into chain
    logic emit;       // hand digest to output, restart message
  } sha256_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic block_full;  // the next byte completes the block
    logic pad_two;     // padding spills into a second block
    logic last_round;
    logic out_busy;
  } sha256_status_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ----- rtl/core/sha256_ctrl.sv -----
// Controller for the SHA-256 hasher: sequences absorb, compression rounds,
// padding blocks and digest hand-off. Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       msg_valid,
  input  logic                       kind,
  output logic                       msg_ready,
  input  sha256_pkg::sha256_status_t sts,
  output sha256_pkg::sha256_cmd_t    cmd
);
  import sha256_pkg::*;

  sha256_state_t state, state_next;
  logic finishing;  // current block sequence ends in a digest
  logic pending;    // a length-only block still follows

  // State register and sequence flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      finishing <= 1'b0;
      pending   <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        finishing <= 1'b1;
        pending   <= sts.pad_two;
      end
      if (cmd.len_block) pending <= 1'b0;
      if (cmd.emit) finishing <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          if (kind == KIND_FINISH || sts.block_full) state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (sts.last_round) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        if (!finishing) state_next = ST_IDLE;
        else if (pending) state_next = ST_PAD2;
        else state_next = ST_DONE;
      end
      ST_PAD2: state_next = ST_ROUND;
      ST_DONE: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    msg_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        msg_ready = 1'b1;
        if (msg_valid) begin
          if (kind == KIND_FINISH) begin
            cmd.finish = 1'b1;
            cmd.start  = 1'b1;
          end else begin
            cmd.absorb = 1'b1;
            cmd.start  = sts.block_full;
          end
        end
      end
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD:  cmd.fold = 1'b1;
      ST_PAD2: begin
        cmd.len_block = 1'b1;
        cmd.start     = 1'b1;
      end
      ST_DONE:  cmd.emit = !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/sha256_dp.sv -----
// Datapath for the SHA-256 hasher: block window with rolling message schedule,
// one round unit, chaining state, length counter and digest output shifter.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 data_byte,
  input  sha256_pkg::sha256_cmd_t    cmd,
  output sha256_pkg::sha256_status_t sts,
  output logic                       digest_valid,
  input  logic                       digest_ready,
  output sha256_pkg::digest_beat_t   digest
);
  import sha256_pkg::*;

  logic [31:0] win [16];     // schedule window, win[0] is this round's word
  logic [31:0] wk [8];       // working variables a..h
  logic [31:0] chain [8];
  logic [31:0] dig [8];      // digest being shipped out
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic [5:0]  rnd;
  logic [2:0]  ocnt;
  logic        busy;

  logic [63:0] bit_len;
  logic [31:0] pad_win [16];
  logic [31:0] len_win [16];
  logic [31:0] w_new, t1, t2, ch, maj;

  assign bit_len = {msg_bytes, 3'b000};

  // First padded block: keep, marker, zeros, length when it fits
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      for (int l = 0; l < 4; l++) begin
        logic [5:0] idx;
        idx = 6'(j * 4 + l);
        if (idx < fill) pad_win[j][8*(3-l) +: 8] = win[j][8*(3-l) +: 8];
        else if (idx == fill) pad_win[j][8*(3-l) +: 8] = PAD_MARK;
        else pad_win[j][8*(3-l) +: 8] = 8'h00;
      end
    end
    if (fill < LEN_POS) begin
      pad_win[14] = bit_len[63:32];
      pad_win[15] = bit_len[31:0];
    end
  end

  // Extra block holding only the length
  always_comb begin
    for (int j = 0; j < 14; j++) len_win[j] = '0;
    len_win[14] = bit_len[63:32];
    len_win[15] = bit_len[31:0];
  end

  // Round unit and schedule expansion
  always_comb begin
    w_new = win[0] + small_sigma0(win[1]) + win[9] + small_sigma1(win[14]);
    ch    = (wk[4] & wk[5]) ^ (~wk[4] & wk[6]);
    maj   = (wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]);
    t1    = wk[7] + big_sigma1(wk[4]) + ch + ROUND_K[rnd] + win[0];
    t2    = big_sigma0(wk[0]) + maj;
  end

  // Block window
  always_ff @(posedge clk) begin
    if (cmd.absorb) begin
      for (int j = 0; j < 16; j++) begin
        for (int l = 0; l < 4; l++) begin
          if (fill == 6'(j * 4 + l)) win[j][8*(3-l) +: 8] <= data_byte;
        end
      end
    end
    if (cmd.finish) win <= pad_win;
    if (cmd.len_block) win <= len_win;
    if (cmd.round) begin
      for (int j = 0; j < 15; j++) win[j] <= win[j+1];
      win[15] <= w_new;
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      wk <= chain;
    end else if (cmd.round) begin
      wk[7] <= wk[6];
      wk[6] <= wk[5];
      wk[5] <= wk[4];
      wk[4] <= wk[3] + t1;
      wk[3] <= wk[2];
      wk[2] <= wk[1];
      wk[1] <= wk[0];
      wk[0] <= t1 + t2;
    end
  end

  // Control counters and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      chain     <= INIT_H;
      fill      <= '0;
      msg_bytes <= '0;
      rnd       <= '0;
    end else begin
      if (cmd.absorb) begin
        fill      <= fill + 6'd1;
        msg_bytes <= msg_bytes + 61'd1;
      end
      if (cmd.start) rnd <= '0;
      else if (cmd.round) rnd <= rnd + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + wk[i];
      end
      if (cmd.emit) begin
        chain     <= INIT_H;
        fill      <= '0;
        msg_bytes <= '0;
      end
    end
  end

  // Digest output: shift out one word per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ocnt <= '0;
    end else if (cmd.emit) begin
      busy <= 1'b1;
      ocnt <= '0;
    end else if (busy && digest_ready) begin
      ocnt <= ocnt + 3'd1;
      if (ocnt == LAST_INDEX) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dig <= chain;
    end else if (busy && digest_ready) begin
      for (int i = 0; i < 7; i++) dig[i] <= dig[i+1];
    end
  end

  assign digest_valid       = busy;
  assign digest.digest_word = dig[0];
  assign digest.word_index  = ocnt;
  assign digest.last_word   = (ocnt == LAST_INDEX);

  assign sts.block_full = (fill == LAST_FILL);
  assign sts.pad_two    = (fill >= LEN_POS);
  assign sts.last_round = (rnd == LAST_ROUND);
  assign sts.out_busy   = busy;

endmodule

// ----- rtl/core/sha256_hasher.sv -----
// Top level of the SHA-256 byte-stream hasher.
// Depends on sha256_pkg, sha256_ctrl and sha256_dp.
//
// Usage:
//   msg channel (msg_valid/msg_ready/msg): each beat is one item. kind = absorb
//   appends data_byte to the message; kind = finish pads, compresses and
//   queues the eight digest words, then starts a fresh message.
//   digest channel (digest_valid/digest_ready/digest): eight beats per finish,
//   word_index 0..7, last_word set on the eighth.
// Flow control:
//   An absorb beat is taken whenever the controller is idle. The beat that
//   completes a 64-byte block holds msg_ready low while the single round unit
//   runs the 64 rounds and the result is folded into the chaining state.
//   A finish compresses the padded block, plus a length-only block when the
//   padding needs one, then words go out one per cycle while the receiver is
//   ready. The digest has its own shift register, so next-message absorbs run
//   while the receiver stalls; a further finish's digest waits until it drains.
// Reset: synchronous rst restores the initial hash values and clears the
//   byte counts; no digest beat is pending after reset.
`timescale 1ns / 1ps

module sha256_hasher (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     msg_valid,
  output logic                     msg_ready,
  input  sha256_pkg::msg_beat_t    msg,
  output logic                     digest_valid,
  input  logic                     digest_ready,
  output sha256_pkg::digest_beat_t digest
);
  import sha256_pkg::*;

  sha256_cmd_t    cmd;
  sha256_status_t sts;

  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .kind      (msg.kind),
    .msg_ready (msg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sha256_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (msg.data_byte),
    .cmd          (cmd),
    .sts          (sts),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

  // A finish beat always starts compression, so input stalls next cycle
  a_finish_stalls: assert property (@(posedge clk) disable iff (rst)
    msg_valid && msg_ready && msg.kind == KIND_FINISH |=> !msg_ready)
    else $error("message taken during compression");

  // Digest words leave in order
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && !digest.last_word |=>
      digest_valid && digest.word_index == $past(digest.word_index) + 3'd1)
    else $error("digest word order broken");

  // A digest starts at word zero
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(digest_valid) |-> digest.word_index == 3'd0)
    else $error("digest does not start at word zero");

  // The last word closes the digest
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && digest.last_word |=> !digest_valid)
    else $error("digest beats after the last word");

endmodule

// ----- test/tb.sv -----
// Testbench for sha256_hasher: drives message beats, predicts the eight digest
// words of every finished message and checks them as they come out.
// Depends on sha256_pkg and the sha256_hasher RTL.
`timescale 1ns / 1ps

import sha256_pkg::*;

// SHA-256 round constants and initial hash values
localparam bit [31:0] RND_K [64] = '{
  32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
  32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
  32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
  32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
  32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
  32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
  32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
  32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
  32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
  32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
  32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
  32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
  32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
  32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
  32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
  32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
};

localparam bit [31:0] IV_WORDS [8] = '{
  32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
  32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
};

localparam bit [7:0] PAD_BYTE    = 8'h80;
localparam int       LEN_OFFSET  = 56;
localparam int       BLOCK_BYTES = 64;
localparam int       MAX_REPORTS = 10;

// Hash predictor plus queue of digest words still owed by the block
class digest_scoreboard;
  bit [31:0]    chain [8];
  bit [7:0]     block [64];
  int           fill;
  bit [60:0]    msg_len;
  digest_beat_t owed_words [$];
  int           mismatches;
  int           msg_beats;
  int           digests;
  int           two_block_pads;
  int           words_checked;

  function new();
    chain = IV_WORDS;
    fill = 0;
    msg_len = '0;
    mismatches = 0;
    msg_beats = 0;
    digests = 0;
    two_block_pads = 0;
    words_checked = 0;
  endfunction

  function bit [31:0] rotr(bit [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of the block buffer into the chain
  function void fold_block();
    bit [31:0] w [64];
    bit [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + RND_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  // Accepted message beat: absorb a byte, or pad and queue the digest
  function void note_msg_beat(msg_beat_t beat);
    bit [63:0]    bit_len;
    int           pos;
    digest_beat_t word;
    msg_beats++;
    if (beat.kind == KIND_ABSORB) begin
      block[fill] = beat.data_byte;
      fill++;
      msg_len++;
      if (fill == BLOCK_BYTES) begin
        fold_block();
        fill = 0;
      end
      return;
    end
    bit_len = {msg_len, 3'b000};
    pos = fill;
    block[pos] = PAD_BYTE;
    pos++;
    // length field no longer fits: close this block with zeros first
    if (pos > LEN_OFFSET) begin
      while (pos < BLOCK_BYTES) begin
        block[pos] = 8'h00;
        pos++;
      end
      fold_block();
      pos = 0;
      two_block_pads++;
    end
    while (pos < LEN_OFFSET) begin
      block[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++)
      block[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
    fold_block();
    for (int i = 0; i < 8; i++) begin
      word.digest_word = chain[i];
      word.word_index = i[2:0];
      word.last_word = (i == 7);
      owed_words = {owed_words, word};
    end
    digests++;
    chain = IV_WORDS;
    fill = 0;
    msg_len = '0;
  endfunction

  // Accepted digest beat against the oldest owed word
  function void check_digest_beat(digest_beat_t got);
    digest_beat_t want;
    if (owed_words.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: unexpected digest beat word=%h idx=%0d last=%0b",
                 got.digest_word, got.word_index, got.last_word);
      return;
    end
    want = owed_words.pop_front();
    words_checked++;
    if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
        got.last_word !== want.last_word) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: digest beat exp word=%h idx=%0d last=%0b, got word=%h idx=%0d last=%0b",
                 want.digest_word, want.word_index, want.last_word,
                 got.digest_word, got.word_index, got.last_word);
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_BEATS  = 40;
  localparam int PHASE_MSGS   = 3;
  localparam int DRAIN_CYCLES = 150;

  logic         clk;
  logic         rst;
  logic         msg_valid;
  logic         msg_ready;
  msg_beat_t    msg;
  logic         digest_valid;
  logic         digest_ready;
  digest_beat_t digest;

  digest_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int cycles;
  int phase_beats;
  int phase_msgs;
  int len_edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  sha256_hasher dut (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_ready    (msg_ready),
    .msg          (msg),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Cycle budget
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random backpressure on the digest channel
  always @(negedge clk) begin
    if (rst)
      digest_ready <= 1'b0;
    else
      digest_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Digest beat monitor
  always @(posedge clk) begin
    if (!rst && digest_valid && digest_ready)
      sb.check_digest_beat(digest);
  end

  // One message beat; entered and left at a falling edge
  task send_beat(input logic kind, input logic [7:0] data);
    msg_beat_t beat;
    beat.kind = kind;
    beat.data_byte = data;
    while ($urandom_range(99) < send_idle_pct) begin
      msg_valid <= 1'b0;
      @(negedge clk);
    end
    msg_valid <= 1'b1;
    msg <= beat;
    @(posedge clk);
    while (!msg_ready)
      @(posedge clk);
    sb.note_msg_beat(beat);
    phase_beats++;
    @(negedge clk);
  endtask

  // Random-content message of the given length, then a finish
  task send_message(input int len);
    for (int i = 0; i < len; i++)
      send_beat(KIND_ABSORB, 8'($urandom));
    send_beat(KIND_FINISH, 8'($urandom));
    phase_msgs++;
  endtask

  // Hold the sender off until every owed digest word is out
  task wait_drained();
    msg_valid <= 1'b0;
    @(negedge clk);
    while (sb.owed_words.size() != 0)
      @(negedge clk);
  endtask

  // Mostly short messages, some right at the padding boundaries
  task run_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    phase_beats = 0;
    phase_msgs = 0;
    while (phase_beats < PHASE_BEATS || phase_msgs < PHASE_MSGS) begin
      if ($urandom_range(9) < 6)
        send_message($urandom_range(15));
      else
        send_message(len_edges[$urandom_range(9)]);
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    msg_valid = 1'b0;
    msg = '0;
    send_idle_pct = 15;
    recv_idle_pct = 55;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty message with an ignored all-ones byte
    send_beat(KIND_FINISH, 8'hff);
    // "abc"
    send_beat(KIND_ABSORB, 8'h61);
    send_beat(KIND_ABSORB, 8'h62);
    send_beat(KIND_ABSORB, 8'h63);
    send_beat(KIND_FINISH, 8'h00);
    // byte extremes and the marker value as data
    send_beat(KIND_ABSORB, 8'h00);
    send_beat(KIND_ABSORB, 8'hff);
    send_beat(KIND_ABSORB, 8'h80);
    send_beat(KIND_ABSORB, 8'h7f);
    send_beat(KIND_FINISH, 8'h5a);
    // back-to-back finishes: state must restart each time
    send_beat(KIND_FINISH, 8'h00);
    send_beat(KIND_FINISH, 8'hff);
    send_beat(KIND_ABSORB, 8'h00);
    send_beat(KIND_FINISH, 8'ha5);
    wait_drained();

    run_phase(15, 55);
    run_phase(55, 15);
    run_phase(0, 0);

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d message beats and %0d digests (%0d words checked),",
             sb.msg_beats, sb.digests, sb.words_checked);
    $display("%0d of them padded into a second block, under three idle mixes.",
             sb.two_block_pads);
    if (sb.mismatches == 0 && sb.owed_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d digest words never seen",
               sb.mismatches, sb.owed_words.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/sha256_pkg.sv
rtl/core/sha256_ctrl.sv
rtl/core/sha256_dp.sv
rtl/core/sha256_hasher.sv
test/tb.sv
